// ===== rtl/core/lsrs_pkg.sv =====
// Package for the lidar sector range steering block.
// Holds the transaction structs, register indexes, reset values, steering codes
// and the controller/datapath interface structs. Depends on nothing.
package lsrs_pkg;

  // Default values of the top-level parameters.
  localparam int DefaultWindow       = 5;
  localparam int DefaultSectorOffset = 42;
  localparam int DefaultMaxScan      = 4096;

  // Fixed field widths.
  localparam int RangeW   = 16;
  localparam int ScanLenW = 13;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;
  localparam int SteerW   = 3;
  localparam int VoteW    = 5;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_SCAN_LENGTH    = 3'd0,
    CFG_RANGE_MIN      = 3'd1,
    CFG_RANGE_MAX      = 3'd2,
    CFG_HARD_RIGHT     = 3'd3,
    CFG_MEDIUM_RIGHT   = 3'd4,
    CFG_SLIGHT_RIGHT   = 3'd5,
    CFG_STRAIGHT_BELOW = 3'd6,
    CFG_STRAIGHT_ABOVE = 3'd7
  } lsrs_cfg_reg_e;

  // Register reset values.
  localparam logic [ScanLenW-1:0] ResetScanLength    = 13'd360;
  localparam logic [RangeW-1:0]   ResetRangeMin      = 16'd20;
  localparam logic [RangeW-1:0]   ResetRangeMax      = 16'd6000;
  localparam logic [RangeW-1:0]   ResetHardRight     = 16'd500;
  localparam logic [RangeW-1:0]   ResetMediumRight   = 16'd600;
  localparam logic [RangeW-1:0]   ResetSlightRight   = 16'd1200;
  localparam logic [RangeW-1:0]   ResetStraightBelow = 16'd1500;
  localparam logic [RangeW-1:0]   ResetStraightAbove = 16'd1650;

  // Steering codes.
  localparam logic [SteerW-1:0] STEER_HARD_RIGHT   = 3'd0;
  localparam logic [SteerW-1:0] STEER_MEDIUM_RIGHT = 3'd1;
  localparam logic [SteerW-1:0] STEER_SLIGHT_RIGHT = 3'd2;
  localparam logic [SteerW-1:0] STEER_STRAIGHT     = 3'd3;
  localparam logic [SteerW-1:0] STEER_LEFT         = 3'd4;

  // Vote array slot that each steering code sets.
  function automatic logic [VoteW-1:0] vote_slot(input logic [SteerW-1:0] cmd);
    logic [VoteW-1:0] slot;
    unique case (cmd)
      STEER_HARD_RIGHT:   slot = 5'd11;
      STEER_MEDIUM_RIGHT: slot = 5'd12;
      STEER_SLIGHT_RIGHT: slot = 5'd13;
      STEER_STRAIGHT:     slot = 5'd16;
      STEER_LEFT:         slot = 5'd18;
      default:            slot = 5'd0;
    endcase
    return slot;
  endfunction

  typedef struct packed {
    logic              first_of_scan;
    logic [RangeW-1:0] range_mm;
    logic              range_is_nan;
  } lsrs_in_item_t;

  typedef struct packed {
    logic [RangeW-1:0] filtered_range_mm;
    logic              filtered_is_nan;
    logic              command_valid;
    logic [SteerW-1:0] steer_command;
    logic [VoteW-1:0]  vote_position;
    logic [RangeW-1:0] scan_average_mm;
    logic [RangeW-1:0] window_average_mm;
    logic              no_data;
  } lsrs_out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic filt;
    logic div_start;
    logic div_sel_win;
    logic push;
    logic wsum_step;
    logic load_out;
  } lsrs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_last;
    logic sector_empty;
    logic div_busy;
    logic wsum_last;
    logic no_data;
    logic out_free;
  } lsrs_status_t;

endpackage

// ===== rtl/core/lsrs_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Used by the datapath for both the sector mean and the window mean.
// Depends on nothing.
module lsrs_div #(
  parameter int DividendW = 29,
  parameter int DivisorW  = 13
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DividendW-1:0] dividend_i,
  input  logic [DivisorW-1:0]  divisor_i,
  output logic                 busy_o,
  output logic [DividendW-1:0] quotient_o
);

  localparam int CntW = $clog2(DividendW + 1);

  logic [CntW-1:0]      cnt_q;
  logic [DivisorW-1:0]  rem_q;
  logic [DivisorW-1:0]  div_q;
  logic [DividendW-1:0] quo_q;
  logic [DivisorW:0]    trial;
  logic [DivisorW:0]    diff;
  logic                 fits;

  assign trial = {rem_q, quo_q[DividendW-1]};
  assign fits  = trial >= {1'b0, div_q};
  assign diff  = trial - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CntW'(DividendW);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (cnt_q != '0) begin
      rem_q <= fits ? diff[DivisorW-1:0] : trial[DivisorW-1:0];
      quo_q <= {quo_q[DividendW-2:0], fits};
    end
  end

  assign busy_o     = cnt_q != '0;
  assign quotient_o = quo_q;

endmodule

// ===== rtl/core/lsrs_ctrl.sv =====
// Controller state machine of the lidar sector range steering block.
// Sequences filtering, the two divisions, the window update and the output load.
// Depends on lsrs_pkg.
module lsrs_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  lsrs_pkg::lsrs_status_t status_i,
  output lsrs_pkg::lsrs_cmd_t    cmd_o
);
  import lsrs_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE      = 9'b000000001,
    ST_FILT      = 9'b000000010,
    ST_SDIV_GO   = 9'b000000100,
    ST_SDIV_WAIT = 9'b000001000,
    ST_PUSH      = 9'b000010000,
    ST_WSUM      = 9'b000100000,
    ST_WDIV_GO   = 9'b001000000,
    ST_WDIV_WAIT = 9'b010000000,
    ST_EMIT      = 9'b100000000
  } lsrs_state_e;

  lsrs_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.load_in = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_FILT;
        end
      end
      ST_FILT: begin
        cmd_o.filt = 1'b1;
        state_d = status_i.is_last ? ST_SDIV_GO : ST_EMIT;
      end
      ST_SDIV_GO: begin
        // An empty sector skips the division; its window entry is invalid.
        if (status_i.sector_empty) begin
          state_d = ST_PUSH;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d = ST_SDIV_WAIT;
        end
      end
      ST_SDIV_WAIT: begin
        if (!status_i.div_busy) begin
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        cmd_o.push = 1'b1;
        state_d = ST_WSUM;
      end
      ST_WSUM: begin
        cmd_o.wsum_step = 1'b1;
        if (status_i.wsum_last) begin
          state_d = ST_WDIV_GO;
        end
      end
      ST_WDIV_GO: begin
        cmd_o.div_sel_win = 1'b1;
        if (status_i.no_data) begin
          state_d = ST_EMIT;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d = ST_WDIV_WAIT;
        end
      end
      ST_WDIV_WAIT: begin
        cmd_o.div_sel_win = 1'b1;
        if (!status_i.div_busy) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = state_q != ST_IDLE;

endmodule

// ===== rtl/core/lsrs_dpath.sv =====
// Datapath of the lidar sector range steering block: configuration registers,
// sample filter, sector accumulator, scan window, steering ladder and output register.
// Depends on lsrs_pkg and lsrs_div.
module lsrs_dpath #(
  parameter int Window       = lsrs_pkg::DefaultWindow,
  parameter int SectorOffset = lsrs_pkg::DefaultSectorOffset,
  parameter int MaxScan      = lsrs_pkg::DefaultMaxScan
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [lsrs_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [lsrs_pkg::CfgDataW-1:0] cfg_data_i,
  input  lsrs_pkg::lsrs_in_item_t       in_data_i,
  input  lsrs_pkg::lsrs_cmd_t           cmd_i,
  output lsrs_pkg::lsrs_status_t        status_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output lsrs_pkg::lsrs_out_item_t      out_data_o
);
  import lsrs_pkg::*;

  localparam int NW      = $clog2(MaxScan + 1);
  localparam int IdxW    = $clog2(MaxScan);
  localparam int BW      = $clog2(MaxScan + SectorOffset + 1);
  localparam int K       = NW + 1;
  localparam int PW      = NW - 1 + K;
  localparam int SumW    = RangeW + NW;
  localparam int FillW   = $clog2(Window + 1);
  localparam int SlotW   = (Window > 1) ? $clog2(Window) : 1;
  localparam int WsW     = RangeW + FillW;
  localparam int EntryW  = RangeW + 1;
  localparam logic [PW-1:0] RecipThird = PW'((2 ** K + 2) / 3);

  // Configuration registers.
  logic [ScanLenW-1:0] scan_length_q;
  logic [RangeW-1:0]   range_min_q, range_max_q;
  logic [RangeW-1:0]   hard_q, medium_q, slight_q, str_below_q, str_above_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_length_q <= ResetScanLength;
      range_min_q   <= ResetRangeMin;
      range_max_q   <= ResetRangeMax;
      hard_q        <= ResetHardRight;
      medium_q      <= ResetMediumRight;
      slight_q      <= ResetSlightRight;
      str_below_q   <= ResetStraightBelow;
      str_above_q   <= ResetStraightAbove;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SCAN_LENGTH:    scan_length_q <= cfg_data_i[ScanLenW-1:0];
        CFG_RANGE_MIN:      range_min_q   <= cfg_data_i;
        CFG_RANGE_MAX:      range_max_q   <= cfg_data_i;
        CFG_HARD_RIGHT:     hard_q        <= cfg_data_i;
        CFG_MEDIUM_RIGHT:   medium_q      <= cfg_data_i;
        CFG_SLIGHT_RIGHT:   slight_q      <= cfg_data_i;
        CFG_STRAIGHT_BELOW: str_below_q   <= cfg_data_i;
        CFG_STRAIGHT_ABOVE: str_above_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective scan length and band bounds. n/6 is (n/2)/3 by a reciprocal multiply.
  logic [NW-1:0]   n_eff;
  logic [NW-2:0]   half_n;
  logic [PW-1:0]   prod_q;
  logic [NW-1:0]   n6, n4;
  logic [BW-1:0]   sec_lo, sec_hi;

  always_comb begin
    if (scan_length_q == '0) begin
      n_eff = NW'(1);
    end else if (32'(scan_length_q) > 32'(MaxScan)) begin
      n_eff = NW'(MaxScan);
    end else begin
      n_eff = NW'(scan_length_q);
    end
  end

  assign half_n = n_eff[NW-1:1];

  always_ff @(posedge clk_i) begin
    prod_q <= PW'(half_n) * RecipThird;
  end

  assign n6     = NW'(prod_q >> K);
  assign n4     = n_eff >> 2;
  assign sec_lo = BW'(n6) + BW'(SectorOffset);
  assign sec_hi = BW'(n4) + BW'(SectorOffset);

  // Accepted input item.
  lsrs_in_item_t in_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in_q <= in_data_i;
    end
  end

  // Sample filter and sector accumulator.
  logic [IdxW-1:0]   idx_q, idx_cur;
  logic [SumW-1:0]   sum_q, sum_cur, sum_add;
  logic [NW-1:0]     cnt_q, cnt_cur, idx_next;
  logic [RangeW-1:0] val;
  logic              in_sector, in_band, counted, is_last;

  assign idx_cur  = in_q.first_of_scan ? '0 : idx_q;
  assign sum_cur  = in_q.first_of_scan ? '0 : sum_q;
  assign cnt_cur  = in_q.first_of_scan ? '0 : cnt_q;
  assign val      = (!in_q.range_is_nan &&
                     (in_q.range_mm < range_min_q || in_q.range_mm > range_max_q)) ?
                    '0 : in_q.range_mm;
  assign in_sector = BW'(idx_cur) >= sec_lo && BW'(idx_cur) < sec_hi;
  assign in_band   = NW'(idx_cur) >= n6 && NW'(idx_cur) < n4;
  assign counted   = in_sector && !in_q.range_is_nan;
  assign sum_add   = counted ? SumW'(val) : '0;
  assign idx_next  = NW'(idx_cur) + NW'(1);
  assign is_last   = idx_next >= n_eff;

  logic [RangeW-1:0] filt_range_q;
  logic              filt_nan_q, last_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.filt) begin
      filt_range_q <= (in_band && !in_q.range_is_nan) ? val : '0;
      filt_nan_q   <= in_band && in_q.range_is_nan;
      last_q       <= is_last;
    end
  end

  // Divider shared by the sector mean and the window mean.
  logic [SumW-1:0] div_dividend, quo;
  logic [NW-1:0]   div_divisor;
  logic            div_busy;
  logic [WsW-1:0]  wsum_q;
  logic [FillW-1:0] fill_q;

  assign div_dividend = cmd_i.div_sel_win ? SumW'(wsum_q) : sum_q;
  assign div_divisor  = cmd_i.div_sel_win ? NW'(fill_q) : cnt_q;

  lsrs_div #(
    .DividendW(SumW),
    .DivisorW (NW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .busy_o    (div_busy),
    .quotient_o(quo)
  );

  // Scan window. Entries are read only below the fill level.
  logic [EntryW-1:0] win_q [Window];
  logic [EntryW-1:0] entry_new, rd_entry;
  logic [SlotW-1:0]  slot_q, wi_q;
  logic [RangeW-1:0] scan_avg_q;
  logic              nodata_q, wsum_last;

  assign entry_new = (cnt_q != '0) ? {1'b1, quo[RangeW-1:0]} : '0;
  assign rd_entry  = win_q[wi_q];
  assign wsum_last = FillW'(wi_q) == fill_q - FillW'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      win_q[slot_q] <= entry_new;
      scan_avg_q    <= entry_new[RangeW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      sum_q    <= '0;
      cnt_q    <= '0;
      slot_q   <= '0;
      fill_q   <= '0;
      wi_q     <= '0;
      wsum_q   <= '0;
      nodata_q <= 1'b0;
    end else begin
      if (cmd_i.filt) begin
        idx_q <= is_last ? '0 : IdxW'(idx_next);
        sum_q <= sum_cur + sum_add;
        cnt_q <= counted ? cnt_cur + NW'(1) : cnt_cur;
      end else if (cmd_i.push) begin
        sum_q <= '0;
        cnt_q <= '0;
      end
      if (cmd_i.push) begin
        slot_q   <= (slot_q == SlotW'(Window - 1)) ? '0 : slot_q + SlotW'(1);
        fill_q   <= (fill_q < FillW'(Window)) ? fill_q + FillW'(1) : fill_q;
        wi_q     <= '0;
        wsum_q   <= '0;
        nodata_q <= 1'b0;
      end else if (cmd_i.wsum_step) begin
        wsum_q   <= wsum_q + WsW'(rd_entry[RangeW-1:0]);
        nodata_q <= nodata_q | !rd_entry[RangeW];
        wi_q     <= wsum_last ? '0 : wi_q + SlotW'(1);
      end
    end
  end

  // Steering ladder, applied in its listed order.
  logic [RangeW-1:0] wavg;
  logic [SteerW-1:0] steer;

  assign wavg = nodata_q ? '0 : quo[RangeW-1:0];

  always_comb begin
    if (nodata_q) begin
      steer = STEER_LEFT;
    end else if (wavg < hard_q) begin
      steer = STEER_HARD_RIGHT;
    end else if (wavg < medium_q) begin
      steer = STEER_MEDIUM_RIGHT;
    end else if (wavg < slight_q) begin
      steer = STEER_SLIGHT_RIGHT;
    end else if (wavg < str_below_q) begin
      steer = STEER_STRAIGHT;
    end else if (wavg > str_above_q) begin
      steer = STEER_STRAIGHT;
    end else begin
      steer = STEER_LEFT;
    end
  end

  // Output register.
  lsrs_out_item_t out_q;
  logic           out_valid_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.filtered_range_mm <= filt_range_q;
      out_q.filtered_is_nan   <= filt_nan_q;
      out_q.command_valid     <= last_q;
      out_q.steer_command     <= last_q ? steer : '0;
      out_q.vote_position     <= last_q ? vote_slot(steer) : '0;
      out_q.scan_average_mm   <= last_q ? scan_avg_q : '0;
      out_q.window_average_mm <= last_q ? wavg : '0;
      out_q.no_data           <= last_q && nodata_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign status_o.is_last      = is_last;
  assign status_o.sector_empty = cnt_q == '0;
  assign status_o.div_busy     = div_busy;
  assign status_o.wsum_last    = wsum_last;
  assign status_o.no_data      = nodata_q;
  assign status_o.out_free     = !out_valid_q || !out_stall_i;

endmodule

// ===== rtl/core/lidar_sector_range_steering.sv =====
// Top level of the lidar sector range steering block.
// Joins the controller (lsrs_ctrl) and the datapath (lsrs_dpath); depends on lsrs_pkg.
//
// Usage. Range samples enter on the input channel (in_valid_i, in_stall_o,
// in_data_i), one sample per transaction. Every sample yields exactly one result
// transaction on the output channel (out_valid_o, out_stall_i, out_data_o): the
// filtered range, and on the last sample of a scan also the scan mean, window mean,
// steering code and vote slot. Configuration registers are written through
// cfg_valid_i/cfg_index_i/cfg_data_i; cfg_ready_o is always high, and writes are
// expected only while the block has no sample in flight.
// Timing. The block works on one sample at a time. An ordinary sample is registered
// on acceptance, filtered, then loaded into the output register; the next sample can
// be accepted from the cycle in which its result becomes valid. The last sample of a
// scan also passes through the one-bit-per-cycle divider, used for the sector mean
// and then for the window mean unless either has no data, and through the walk over
// the window entries.
// Reset clears the scan index, the sector sums, the window fill level and the
// output valid; configuration returns to its reset values.
// Stalls. A finished result waits in the output register while the receiver
// stalls; one further sample is accepted and processed meanwhile, and the block
// then holds in_stall_o high until the output register is free.
module lidar_sector_range_steering #(
  parameter int Window       = lsrs_pkg::DefaultWindow,
  parameter int SectorOffset = lsrs_pkg::DefaultSectorOffset,
  parameter int MaxScan      = lsrs_pkg::DefaultMaxScan
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  lsrs_pkg::lsrs_in_item_t       in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output lsrs_pkg::lsrs_out_item_t      out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lsrs_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [lsrs_pkg::CfgDataW-1:0] cfg_data_i
);
  import lsrs_pkg::*;

  lsrs_cmd_t    cmd;
  lsrs_status_t status;

  // Registers take every write; the user writes them only while idle.
  assign cfg_ready_o = 1'b1;

  lsrs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  lsrs_dpath #(
    .Window      (Window),
    .SectorOffset(SectorOffset),
    .MaxScan     (MaxScan)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i && cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // The divider is never restarted while a division is still running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |-> !status.div_busy)
    else $error("divider started while busy");

  // A result is never loaded over one that the receiver has not taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> status.out_free)
    else $error("output register overwritten");

  // After accepting a sample the block is busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted on consecutive cycles");

  // Missing window data always steers left.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.no_data) |-> (out_data_o.steer_command == STEER_LEFT))
    else $error("no_data result without left command");

endmodule
